### src/door_motor_sequencer_macros.svh
// assertion macros for the door motor sequencer checker
`ifndef DOOR_MOTOR_SEQUENCER_MACROS_SVH
`define DOOR_MOTOR_SEQUENCER_MACROS_SVH

// same-cycle implication, sampled on clk, idle while arst_n is low
`define DMS_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("door motor sequencer check failed");

// next-cycle implication, sampled on clk, idle while arst_n is low
`define DMS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("door motor sequencer check failed");

`endif

### src/dms_pkg.sv
// types, codes and register defaults for the door motor sequencer
`default_nettype none
package dms_pkg;

	// door modes
	typedef enum logic [2:0] {
		MODE_CLOSED  = 3'd0,
		MODE_OPENED  = 3'd1,
		MODE_CLOSING = 3'd2,
		MODE_OPENING = 3'd3,
		MODE_STOPPED = 3'd4
	} mode_t;

	// motor drive directions
	typedef enum logic [1:0] {
		DIR_STOP  = 2'd0,
		DIR_OPEN  = 2'd1,
		DIR_CLOSE = 2'd2
	} dir_t;

	// event codes reported with each result
	typedef enum logic [3:0] {
		EV_NONE           = 4'd0,
		EV_ALREADY_OPEN   = 4'd1,
		EV_ALREADY_CLOSED = 4'd2,
		EV_CMD_OPEN       = 4'd3,
		EV_CMD_CLOSE      = 4'd4,
		EV_STOP           = 4'd5,
		EV_INVALID        = 4'd6,
		EV_HOT_OPEN       = 4'd7,
		EV_COLD_CLOSE     = 4'd8,
		EV_REACHED_OPEN   = 4'd9,
		EV_REACHED_CLOSED = 4'd10
	} event_t;

	// request types
	localparam logic REQ_TICK = 1'b0;
	localparam logic REQ_CMD  = 1'b1;

	// command bytes ('0', '1', '2')
	localparam logic [7:0] CMD_STOP  = 8'h30;
	localparam logic [7:0] CMD_OPEN  = 8'h31;
	localparam logic [7:0] CMD_CLOSE = 8'h32;

	// register indexes
	localparam int unsigned CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_HIGH_TEMP      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LOW_TEMP       = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_OPEN_TILT      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CLOSED_TILT    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_COOLDOWN_TICKS = 3'd4;
	localparam int unsigned CFG_DATA_W = 16;

	// register reset values (tilt in Q3.12: 0.9 g and 0.05 g)
	localparam logic [7:0]         HIGH_TEMP_RST      = 8'd30;
	localparam logic [7:0]         LOW_TEMP_RST       = 8'd23;
	localparam logic signed [15:0] OPEN_TILT_RST      = 16'sd3686;
	localparam logic signed [15:0] CLOSED_TILT_RST    = 16'sd205;
	localparam logic [6:0]         COOLDOWN_TICKS_RST = 7'd30;

	// configuration bundle
	typedef struct packed {
		logic [7:0]         high_temp;
		logic [7:0]         low_temp;
		logic signed [15:0] open_tilt;
		logic signed [15:0] closed_tilt;
		logic [6:0]         cooldown_ticks;
	} cfg_t;

	// one input item
	typedef struct packed {
		logic               req_type;
		logic [7:0]         command_char;
		logic [7:0]         temperature;
		logic signed [15:0] tilt_z;
	} item_t;

	// sequencer state
	typedef struct packed {
		mode_t      mode;
		dir_t       dir;
		logic       cooling;
		logic [6:0] tick_count;
	} state_t;

	// one result item
	typedef struct packed {
		dir_t       motor_dir;
		mode_t      door_state;
		event_t     event_code;
		logic       was_cooling;
		logic [6:0] cooldown_left;
		logic       cooldown_done;
	} result_t;

endpackage
`default_nettype wire

### src/dms_cfg_regs.sv
// configuration register bank of the door motor sequencer
`default_nettype none
module dms_cfg_regs (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_wen,
	input  wire logic [dms_pkg::CFG_IDX_W-1:0]   cfg_idx,
	input  wire logic [dms_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	output dms_pkg::cfg_t                        cfg
);
	import dms_pkg::*;

	cfg_t cfg_q;

	// register writes, unknown indexes ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.high_temp      <= HIGH_TEMP_RST;
			cfg_q.low_temp       <= LOW_TEMP_RST;
			cfg_q.open_tilt      <= OPEN_TILT_RST;
			cfg_q.closed_tilt    <= CLOSED_TILT_RST;
			cfg_q.cooldown_ticks <= COOLDOWN_TICKS_RST;
		end else if (cfg_wen) begin
			unique case (cfg_idx)
				REG_HIGH_TEMP:      cfg_q.high_temp      <= cfg_wdata[7:0];
				REG_LOW_TEMP:       cfg_q.low_temp       <= cfg_wdata[7:0];
				REG_OPEN_TILT:      cfg_q.open_tilt      <= signed'(cfg_wdata[15:0]);
				REG_CLOSED_TILT:    cfg_q.closed_tilt    <= signed'(cfg_wdata[15:0]);
				REG_COOLDOWN_TICKS: cfg_q.cooldown_ticks <= cfg_wdata[6:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule
`default_nettype wire

### src/dms_step.sv
// next-state and result logic for one item of the door motor sequencer
`default_nettype none
module dms_step (
	input  dms_pkg::cfg_t    cfg,
	input  dms_pkg::state_t  cur,
	input  dms_pkg::item_t   item,
	output dms_pkg::state_t  nxt,
	output dms_pkg::result_t res
);
	import dms_pkg::*;

	event_t     ev;
	logic       was;
	logic [6:0] left;
	logic       done;

	always_comb begin
		nxt  = cur;
		ev   = EV_NONE;
		was  = 1'b0;
		left = '0;
		done = 1'b0;

		if (item.req_type == REQ_CMD) begin
			// remaining cooldown, saturating at zero
			if (cur.cooling) begin
				was = 1'b1;
				if (cfg.cooldown_ticks >= cur.tick_count) begin
					left = cfg.cooldown_ticks - cur.tick_count;
				end
			end
			// command decode
			priority if (item.command_char == CMD_OPEN) begin
				if (cur.mode == MODE_OPENED) begin
					ev = EV_ALREADY_OPEN;
				end else begin
					nxt.mode       = MODE_OPENING;
					nxt.dir        = DIR_OPEN;
					nxt.tick_count = '0;
					nxt.cooling    = 1'b1;
					ev             = EV_CMD_OPEN;
				end
			end else if (item.command_char == CMD_CLOSE) begin
				if (cur.mode == MODE_CLOSED) begin
					ev = EV_ALREADY_CLOSED;
				end else begin
					nxt.mode       = MODE_CLOSING;
					nxt.dir        = DIR_CLOSE;
					nxt.tick_count = '0;
					nxt.cooling    = 1'b1;
					ev             = EV_CMD_CLOSE;
				end
			end else if (item.command_char == CMD_STOP) begin
				nxt.mode       = MODE_STOPPED;
				nxt.dir        = DIR_STOP;
				nxt.tick_count = '0;
				nxt.cooling    = 1'b1;
				ev             = EV_STOP;
			end else begin
				// unknown byte halts the motor, mode kept
				nxt.dir = DIR_STOP;
				ev      = EV_INVALID;
			end
		end else begin
			// temperature moves and tilt completion
			unique case (cur.mode)
				MODE_CLOSED: begin
					if (item.temperature >= cfg.high_temp && !cur.cooling) begin
						nxt.mode    = MODE_OPENING;
						nxt.dir     = DIR_OPEN;
						nxt.cooling = 1'b1;
						ev          = EV_HOT_OPEN;
					end
				end
				MODE_OPENED: begin
					if (item.temperature <= cfg.low_temp && !cur.cooling) begin
						nxt.mode    = MODE_CLOSING;
						nxt.dir     = DIR_CLOSE;
						nxt.cooling = 1'b1;
						ev          = EV_COLD_CLOSE;
					end
				end
				MODE_OPENING: begin
					if (item.tilt_z >= cfg.open_tilt) begin
						nxt.mode = MODE_OPENED;
						nxt.dir  = DIR_STOP;
						ev       = EV_REACHED_OPEN;
					end
				end
				MODE_CLOSING: begin
					if (item.tilt_z <= cfg.closed_tilt) begin
						nxt.mode = MODE_CLOSED;
						nxt.dir  = DIR_STOP;
						ev       = EV_REACHED_CLOSED;
					end
				end
				default: ;
			endcase
			// cooldown count, after the mode rule
			if (nxt.cooling) begin
				if (cur.tick_count >= cfg.cooldown_ticks) begin
					nxt.tick_count = '0;
					nxt.cooling    = 1'b0;
					done           = 1'b1;
				end else begin
					nxt.tick_count = cur.tick_count + 7'd1;
				end
			end
		end

		res.motor_dir     = nxt.dir;
		res.door_state    = nxt.mode;
		res.event_code    = ev;
		res.was_cooling   = was;
		res.cooldown_left = left;
		res.cooldown_done = done;
	end

endmodule
`default_nettype wire

### src/door_motor_sequencer.sv
// top level of the door motor sequencer: input register, step logic, result register
//
//   channel  direction  handshake              payload
//   in       in         in_valid / in_stall    req_type, command_char, temperature, tilt_z
//   out      out        out_valid / out_stall  motor_dir, door_state, event_code,
//                                              was_cooling, cooldown_left, cooldown_done
//   cfg      in         cfg_wen                cfg_idx, cfg_wdata
//
// one item per cycle sustained while out_stall is low; a result passes the input register and then
// the result register after its transaction on the input channel, and is taken at an edge with out_stall low
// the state update and the result are formed together in one pass of the step logic
// arst_n clears the state, the configuration registers to their defaults and both valid flags
// out_stall holds the result register; the input register then fills and in_stall rises
`default_nettype none
module door_motor_sequencer (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            in_valid,
	output logic                                 in_stall,
	input  wire logic                            req_type,
	input  wire logic [7:0]                      command_char,
	input  wire logic [7:0]                      temperature,
	input  wire logic signed [15:0]              tilt_z,
	output logic                                 out_valid,
	input  wire logic                            out_stall,
	output logic [1:0]                           motor_dir,
	output logic [2:0]                           door_state,
	output logic [3:0]                           event_code,
	output logic                                 was_cooling,
	output logic [6:0]                           cooldown_left,
	output logic                                 cooldown_done,
	input  wire logic                            cfg_wen,
	input  wire logic [dms_pkg::CFG_IDX_W-1:0]   cfg_idx,
	input  wire logic [dms_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
	import dms_pkg::*;

	cfg_t    cfg;
	item_t   item_s1;
	logic    valid_s1;
	state_t  state_q;
	state_t  state_nxt;
	result_t res_nxt;
	result_t res_s2;
	logic    valid_s2;
	logic    in_take;
	logic    advance;

	// configuration registers
	dms_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	// step logic
	dms_step u_step (
		.cfg  (cfg),
		.cur  (state_q),
		.item (item_s1),
		.nxt  (state_nxt),
		.res  (res_nxt)
	);

	// handshake: the held item moves on when the result register is free or draining
	assign advance  = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign in_take  = in_valid && !in_stall;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			item_s1.req_type     <= req_type;
			item_s1.command_char <= command_char;
			item_s1.temperature  <= temperature;
			item_s1.tilt_z       <= tilt_z;
		end
	end

	// sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.mode       <= MODE_CLOSED;
			state_q.dir        <= DIR_STOP;
			state_q.cooling    <= 1'b0;
			state_q.tick_count <= '0;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res_nxt;
		end
	end

	assign out_valid     = valid_s2;
	assign motor_dir     = res_s2.motor_dir;
	assign door_state    = res_s2.door_state;
	assign event_code    = res_s2.event_code;
	assign was_cooling   = res_s2.was_cooling;
	assign cooldown_left = res_s2.cooldown_left;
	assign cooldown_done = res_s2.cooldown_done;

endmodule
`default_nettype wire

### src/dms_checker.sv
// port-level checks for the door motor sequencer, bound to the top level
`default_nettype none
`include "door_motor_sequencer_macros.svh"
module dms_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       out_valid,
	input wire logic       out_stall,
	input wire logic [1:0] motor_dir,
	input wire logic [2:0] door_state,
	input wire logic [3:0] event_code,
	input wire logic       was_cooling,
	input wire logic [6:0] cooldown_left,
	input wire logic       cooldown_done
);
	import dms_pkg::*;

	// a stalled result stays offered
	`DMS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)

	// remaining cooldown only reported for a command during a cooldown
	`DMS_ASSERT_NOW(a_left_needs_cooling, out_valid && !was_cooling, cooldown_left == 7'd0)

	// cooldown end only on ticks, never alongside a command flag
	`DMS_ASSERT_NOW(a_done_on_tick, out_valid && cooldown_done, !was_cooling)

	// reaching the open end stops the motor in the opened mode
	`DMS_ASSERT_NOW(a_reached_open, out_valid && event_code == EV_REACHED_OPEN,
		motor_dir == DIR_STOP && door_state == MODE_OPENED)

	// an opening motor always matches the opening mode
	`DMS_ASSERT_NOW(a_dir_mode, out_valid && motor_dir == DIR_OPEN, door_state == MODE_OPENING)

endmodule

bind door_motor_sequencer dms_checker u_dms_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (out_valid),
	.out_stall     (out_stall),
	.motor_dir     (motor_dir),
	.door_state    (door_state),
	.event_code    (event_code),
	.was_cooling   (was_cooling),
	.cooldown_left (cooldown_left),
	.cooldown_done (cooldown_done)
);
`default_nettype wire
